### sv/lru_stack_distance_profiler_macros.svh
// assertion macros for the stack distance profiler
`ifndef LRU_STACK_DISTANCE_PROFILER_MACROS_SVH
`define LRU_STACK_DISTANCE_PROFILER_MACROS_SVH

// implication checked on every clock edge outside reset
`define LSDP_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication checked outside reset
`define LSDP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### sv/lsdp_pkg.sv
// ----------------------------------------------------------------------------
// lsdp_pkg
// shared types and constants of the stack distance profiler
// ----------------------------------------------------------------------------
`default_nettype none
package lsdp_pkg;

   localparam int unsigned FUNC_ACCESS = 0;
   localparam int unsigned FUNC_READ   = 1;

   // commands from the controller to the datapath
   typedef struct packed {
      logic clear_step;   // clear one row of the stack and profile stores
      logic load_req;     // capture the request
      logic read_row;     // issue the set row and profile reads
      logic eval;         // compare and build the new row
      logic write_back;   // write row, profile cell and totals
      logic respond;      // drive the result strobe
   } lsdp_cmd_type;

   // status from the datapath to the controller
   typedef struct packed {
      logic clear_done;
   } lsdp_sts_type;

endpackage
`default_nettype wire

### sv/lru_stack_distance_profiler.sv
// ----------------------------------------------------------------------------
// lru_stack_distance_profiler
// per-set lru stack with reuse-age / stack-position profile table
// ----------------------------------------------------------------------------
// channel   ports                                 handshake
// request   req_func/set_index/tag/row_sel/col_sel start high, busy low
// result    rsp_hit .. rsp_miss_total             rsp_valid, one cycle
//
// the result strobe rises after the accepting edge once the row read,
// compare, write-back and output register steps have each run in turn
// busy is low again in the cycle the result is shown, so a new request
// is accepted only after the previous one has been answered
// after reset a clearing pass over max(NUM_SETS, AGE_ROWS*DEPTH) store
// addresses (6400 by default) runs with busy high
// the receiver cannot stall results
`default_nettype none
module lru_stack_distance_profiler
   import lsdp_pkg::*;
#(
   parameter int unsigned NUM_SETS  = 1024,
   parameter int unsigned BASE_WAYS = 8,
   parameter int unsigned SCALE     = 4,
   parameter int unsigned AGE_ROWS  = 200,
   parameter int unsigned TAG_BITS  = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic        req_func,
   input  wire logic [9:0]  req_set_index,
   input  wire logic [31:0] req_tag,
   input  wire logic [7:0]  req_row_sel,
   input  wire logic [4:0]  req_col_sel,
   output logic             rsp_valid,
   output logic             rsp_hit,
   output logic [4:0]       rsp_hit_position,
   output logic [7:0]       rsp_reuse_age,
   output logic [31:0]      rsp_cell_value,
   output logic [31:0]      rsp_hit_total,
   output logic [31:0]      rsp_miss_total
);

   lsdp_cmd_type cmd;
   lsdp_sts_type sts;

   // sequencer
   lsdp_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .cmd   (cmd),
      .sts   (sts)
   );

   // stores and compare/shift network
   lsdp_datapath #(
      .NUM_SETS  (NUM_SETS),
      .BASE_WAYS (BASE_WAYS),
      .SCALE     (SCALE),
      .AGE_ROWS  (AGE_ROWS),
      .TAG_BITS  (TAG_BITS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .req_func         (req_func),
      .req_set_index    (req_set_index),
      .req_tag          (req_tag),
      .req_row_sel      (req_row_sel),
      .req_col_sel      (req_col_sel),
      .rsp_valid        (rsp_valid),
      .rsp_hit          (rsp_hit),
      .rsp_hit_position (rsp_hit_position),
      .rsp_reuse_age    (rsp_reuse_age),
      .rsp_cell_value   (rsp_cell_value),
      .rsp_hit_total    (rsp_hit_total),
      .rsp_miss_total   (rsp_miss_total)
   );

endmodule
`default_nettype wire

### sv/lsdp_ctrl.sv
// ----------------------------------------------------------------------------
// lsdp_ctrl
// sequencer: clearing pass after reset, then four steps per request
// ----------------------------------------------------------------------------
`default_nettype none
module lsdp_ctrl
   import lsdp_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         start,
   output logic              busy,
   output lsdp_cmd_type      cmd,
   input  wire lsdp_sts_type sts
);

   typedef enum logic [5:0] {
      ST_CLEAR = 6'b000001,
      ST_IDLE  = 6'b000010,
      ST_READ  = 6'b000100,
      ST_EVAL  = 6'b001000,
      ST_WRITE = 6'b010000,
      ST_RESP  = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      busy     = 1'b1;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (sts.clear_done) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.load_req = 1'b1;
               state_in     = ST_READ;
            end
         end
         ST_READ: begin
            cmd.read_row = 1'b1;
            state_in     = ST_EVAL;
         end
         ST_EVAL: begin
            cmd.eval = 1'b1;
            state_in = ST_WRITE;
         end
         ST_WRITE: begin
            cmd.write_back = 1'b1;
            state_in       = ST_RESP;
         end
         ST_RESP: begin
            cmd.respond = 1'b1;
            state_in    = ST_IDLE;
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

endmodule
`default_nettype wire

### sv/lsdp_datapath.sv
// ----------------------------------------------------------------------------
// lsdp_datapath
// stack row store, profile store, compare and shift network, totals
// ----------------------------------------------------------------------------
`default_nettype none
module lsdp_datapath
   import lsdp_pkg::*;
#(
   parameter int unsigned NUM_SETS  = 1024,
   parameter int unsigned BASE_WAYS = 8,
   parameter int unsigned SCALE     = 4,
   parameter int unsigned AGE_ROWS  = 200,
   parameter int unsigned TAG_BITS  = 32
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire lsdp_cmd_type  cmd,
   output lsdp_sts_type       sts,
   input  wire logic          req_func,
   input  wire logic [9:0]    req_set_index,
   input  wire logic [31:0]   req_tag,
   input  wire logic [7:0]    req_row_sel,
   input  wire logic [4:0]    req_col_sel,
   output logic               rsp_valid,
   output logic               rsp_hit,
   output logic [4:0]         rsp_hit_position,
   output logic [7:0]         rsp_reuse_age,
   output logic [31:0]        rsp_cell_value,
   output logic [31:0]        rsp_hit_total,
   output logic [31:0]        rsp_miss_total
);

   localparam int unsigned DEPTH    = SCALE * BASE_WAYS;
   localparam int unsigned POS_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned SET_W    = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
   localparam int unsigned AGE_W    = $clog2(AGE_ROWS + 1);
   localparam int unsigned PROF_W   = $clog2(AGE_ROWS * DEPTH);
   localparam int unsigned CLR_N    = (NUM_SETS > AGE_ROWS * DEPTH) ? NUM_SETS
                                                                   : AGE_ROWS * DEPTH;
   localparam int unsigned CLR_W    = $clog2(CLR_N + 1);
   localparam int unsigned TW       = (TAG_BITS < 32) ? TAG_BITS : 32;
   localparam int unsigned ENT_W    = TW + AGE_W;
   localparam int unsigned ROW_BITS = DEPTH * ENT_W;
   localparam logic [31:0] SAT32    = 32'hFFFF_FFFF;
   localparam logic [AGE_W-1:0] AGE_MAX = AGE_W'(AGE_ROWS);
   // reciprocal of the set count, exact for any 10-bit index below 1024 sets
   localparam int unsigned SET_RECIP = (NUM_SETS >= 1024) ? 1
                                     : ((1 << 20) + NUM_SETS - 1) / NUM_SETS;

   // one memory word holds a whole set row: tag and age per slot
   logic [ROW_BITS-1:0] stack_mem [NUM_SETS];
   logic [31:0]         prof_mem  [AGE_ROWS * DEPTH];

   logic [CLR_W-1:0] clr_ff;
   logic             is_read_ff;
   logic [SET_W-1:0] set_ff;
   logic [TW-1:0]    tag_ff;
   logic             rd_ok_ff;
   logic [PROF_W-1:0] rd_addr_ff;
   logic [ROW_BITS-1:0] row_ff, new_row_ff;
   logic [31:0]      cell_rd_ff;
   logic             hit_ff;
   logic [POS_W-1:0] pos_ff;
   logic [AGE_W-1:0] age_ff;
   logic [PROF_W-1:0] inc_addr_ff;
   logic [31:0]      hit_tot_ff, miss_tot_ff;
   logic             valid_ff;

   // compare and shift network signals
   logic [TW-1:0]    t_c [DEPTH];
   logic [AGE_W-1:0] a_c [DEPTH];
   logic             found_c;
   logic [POS_W-1:0] pos_c;
   logic [AGE_W-1:0] r_c;
   logic [ROW_BITS-1:0] nrow_c;
   logic [PROF_W-1:0] inc_addr_c;
   logic [PROF_W+POS_W:0] inc_full;

   assign sts.clear_done = (clr_ff == CLR_W'(CLR_N - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (cmd.clear_step && !sts.clear_done) begin
         clr_ff <= clr_ff + 1'b1;
      end
   end

   // profile address of a captured read request
   logic [PROF_W+8:0] rd_addr_full;
   assign rd_addr_full = (PROF_W+9)'(req_row_sel) * (PROF_W+9)'(DEPTH)
                       + (PROF_W+9)'(req_col_sel);

   // set index modulo the set count by reciprocal multiply
   logic [29:0] set_prod;
   logic [9:0]  set_quot;
   logic [9:0]  set_mod;
   assign set_prod = 30'(req_set_index) * 30'(SET_RECIP);
   assign set_quot = set_prod[29:20];
   assign set_mod  = (NUM_SETS >= 1024) ? req_set_index
                                        : req_set_index - 10'(set_quot * NUM_SETS);

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         is_read_ff <= req_func;
         set_ff     <= SET_W'(set_mod);
         tag_ff     <= TW'(req_tag);
         rd_ok_ff   <= (32'(req_row_sel) < AGE_ROWS) && (32'(req_col_sel) < DEPTH);
         rd_addr_ff <= PROF_W'(rd_addr_full);
      end
   end

   // store reads and writes
   always_ff @(posedge clock) begin
      if (cmd.clear_step) begin
         if (32'(clr_ff) < NUM_SETS) stack_mem[SET_W'(clr_ff)] <= '0;
         if (32'(clr_ff) < AGE_ROWS * DEPTH) prof_mem[PROF_W'(clr_ff)] <= '0;
      end
      if (cmd.read_row) begin
         row_ff     <= stack_mem[set_ff];
         cell_rd_ff <= prof_mem[rd_addr_ff];
      end
      if (cmd.eval && !is_read_ff) begin
         cell_rd_ff <= prof_mem[inc_addr_c];
      end
      if (cmd.write_back && !is_read_ff) begin
         stack_mem[set_ff] <= new_row_ff;
         if (hit_ff) prof_mem[inc_addr_ff] <= (cell_rd_ff == SAT32) ? cell_rd_ff
                                                                    : cell_rd_ff + 1'b1;
      end
   end

   // compare and shift network over the row
   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         t_c[i] = row_ff[i*ENT_W + AGE_W +: TW];
         a_c[i] = row_ff[i*ENT_W +: AGE_W];
      end
      found_c = 1'b0;
      pos_c   = '0;
      for (int i = DEPTH - 1; i >= 0; i--) begin
         if (t_c[i] == tag_ff) begin
            found_c = 1'b1;
            pos_c   = POS_W'(i);
         end
      end
      r_c = (a_c[pos_c] >= AGE_MAX) ? AGE_MAX : a_c[pos_c] + 1'b1;
      inc_full = (PROF_W+POS_W+1)'(r_c - 1'b1) * (PROF_W+POS_W+1)'(DEPTH)
               + (PROF_W+POS_W+1)'(pos_c);
      inc_addr_c = PROF_W'(inc_full);
      nrow_c = '0;
      nrow_c[AGE_W +: TW]   = tag_ff;
      nrow_c[0 +: AGE_W]    = AGE_W'(1);
      for (int i = 1; i < DEPTH; i++) begin
         logic [TW-1:0]    nt;
         logic [AGE_W-1:0] na;
         if (!found_c || i <= 32'(pos_c)) begin
            nt = t_c[i-1];
            na = a_c[i-1];
         end else begin
            nt = t_c[i];
            na = a_c[i];
         end
         if (nt != '0) na = (na >= AGE_MAX) ? AGE_MAX : na + 1'b1;
         nrow_c[i*ENT_W + AGE_W +: TW] = nt;
         nrow_c[i*ENT_W +: AGE_W]      = na;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.eval) begin
         new_row_ff  <= nrow_c;
         hit_ff      <= found_c && !is_read_ff;
         pos_ff      <= pos_c;
         age_ff      <= r_c;
         inc_addr_ff <= inc_addr_c;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_tot_ff  <= '0;
         miss_tot_ff <= '0;
         valid_ff    <= 1'b0;
      end else begin
         valid_ff <= cmd.respond;
         if (cmd.write_back && !is_read_ff) begin
            if (hit_ff && hit_tot_ff != SAT32) hit_tot_ff <= hit_tot_ff + 1'b1;
            if (!hit_ff && miss_tot_ff != SAT32) miss_tot_ff <= miss_tot_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.respond) begin
         rsp_hit          <= hit_ff;
         rsp_hit_position <= hit_ff ? 5'(pos_ff) : '0;
         rsp_reuse_age    <= hit_ff ? 8'(age_ff) : '0;
         rsp_cell_value   <= (is_read_ff && rd_ok_ff) ? cell_rd_ff : '0;
         rsp_hit_total    <= hit_tot_ff;
         rsp_miss_total   <= miss_tot_ff;
      end
   end

   assign rsp_valid = valid_ff;

endmodule
`default_nettype wire

### sv/lsdp_checker.sv
// ----------------------------------------------------------------------------
// lsdp_checker
// port-level checks of the stack distance profiler
// ----------------------------------------------------------------------------
`default_nettype none
`include "lru_stack_distance_profiler_macros.svh"
module lsdp_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        start,
   input wire logic        busy,
   input wire logic        rsp_valid,
   input wire logic        rsp_hit,
   input wire logic [4:0]  rsp_hit_position,
   input wire logic [7:0]  rsp_reuse_age,
   input wire logic [31:0] rsp_cell_value
);
   `LSDP_ASSERT_NEXT(a_busy_after_accept, clock, reset, start && !busy, busy,
      "busy not raised after accept")
   `LSDP_ASSERT_IMP(a_hit_has_age, clock, reset, rsp_valid && rsp_hit,
      rsp_reuse_age != 8'd0, "hit without reuse age")
   `LSDP_ASSERT_IMP(a_miss_clean, clock, reset, rsp_valid && !rsp_hit,
      rsp_hit_position == 5'd0 && rsp_reuse_age == 8'd0, "miss with hit fields")
   `LSDP_ASSERT_IMP(a_hit_no_cell, clock, reset, rsp_valid && rsp_hit,
      rsp_cell_value == 32'd0, "cell value on an access")
endmodule

bind lru_stack_distance_profiler lsdp_checker u_lsdp_checker (
   .clock            (clock),
   .reset            (reset),
   .start            (start),
   .busy             (busy),
   .rsp_valid        (rsp_valid),
   .rsp_hit          (rsp_hit),
   .rsp_hit_position (rsp_hit_position),
   .rsp_reuse_age    (rsp_reuse_age),
   .rsp_cell_value   (rsp_cell_value)
);
`default_nettype wire
